// ===== rtl/rteu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the R-type execute unit.
// Used by every module of the block; depends on nothing.
package rteu_pkg;

   localparam int unsigned NUM_REGS    = 32;
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned RSP_TDATA_W = 136;
   localparam int unsigned MD_STEPS    = 32;

   // Function field codes.
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_MISALIGN = 2'd2;
   localparam logic [1:0] STAT_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MULDIV
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_RUN,
      MD_FIX,
      MD_DONE
   } md_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic is_signed;
      logic ack;
   } md_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_stat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        reg_wr;
      logic [31:0] value;
      logic        jump;
      logic [29:0] target;
      logic        hi_wr;
      logic        lo_wr;
      logic        md_start;
      logic        md_div;
      logic        md_signed;
   } alu_res_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic        jump_taken;
      logic [29:0] jump_target;
   } rsp_type;

endpackage

// ===== rtl/rteu_regfile.sv =====
`timescale 1ns / 1ps
// General register file: a 32 x 32 synchronous memory with two read ports
// and one write port. Depends on rteu_pkg.
module rteu_regfile import rteu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0]         mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [31:0]         data_a_ff;
   logic [31:0]         data_b_ff;
   logic                valid_a_ff;
   logic                valid_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem_ff[rd_addr_a];
         data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_a_ff <= valid_ff[rd_addr_a];
            valid_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = valid_a_ff ? data_a_ff : '0;
   assign rd_data_b = valid_b_ff ? data_b_ff : '0;

endmodule

// ===== rtl/rteu_alu.sv =====
`timescale 1ns / 1ps
// Combinational decode and execute of the function field: arithmetic, logic,
// shifts, compares, Hi/Lo moves and jump checks. Depends on rteu_pkg.
module rteu_alu import rteu_pkg::*; (
   input  logic [5:0]  funct,
   input  logic [4:0]  shamt,
   input  logic [31:0] opnd_a,
   input  logic [31:0] opnd_b,
   input  logic [31:0] hi,
   input  logic [31:0] lo,
   output alu_res_type res
);

   logic [31:0] sum;
   logic [31:0] diff;
   logic        add_ovf;
   logic        sub_ovf;

   assign sum     = opnd_a + opnd_b;
   assign diff    = opnd_a - opnd_b;
   assign add_ovf = ~(opnd_a[31] ^ opnd_b[31]) & (opnd_a[31] ^ sum[31]);
   assign sub_ovf = (opnd_a[31] ^ opnd_b[31]) & (opnd_a[31] ^ diff[31]);

   always_comb begin
      res = '0;
      case (funct)
         FN_ADD: begin
            if (add_ovf) begin
               res.status = STAT_OVERFLOW;
            end else begin
               res.reg_wr = 1'b1;
               res.value  = sum;
            end
         end
         FN_ADDU: begin
            res.reg_wr = 1'b1;
            res.value  = sum;
         end
         FN_SUB: begin
            if (sub_ovf) begin
               res.status = STAT_OVERFLOW;
            end else begin
               res.reg_wr = 1'b1;
               res.value  = diff;
            end
         end
         FN_SUBU: begin
            res.reg_wr = 1'b1;
            res.value  = diff;
         end
         FN_AND: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_a & opnd_b;
         end
         FN_OR: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_a | opnd_b;
         end
         FN_NOR: begin
            res.reg_wr = 1'b1;
            res.value  = ~(opnd_a | opnd_b);
         end
         FN_SLT: begin
            res.reg_wr = 1'b1;
            res.value  = {31'd0, $signed(opnd_a) < $signed(opnd_b)};
         end
         FN_SLTU: begin
            res.reg_wr = 1'b1;
            res.value  = {31'd0, opnd_a < opnd_b};
         end
         FN_SLL: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_b << shamt;
         end
         FN_SRL: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_b >> shamt;
         end
         FN_SRA: begin
            res.reg_wr = 1'b1;
            res.value  = $signed(opnd_b) >>> shamt;
         end
         FN_SLLV: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_b << opnd_a[4:0];
         end
         FN_SRLV: begin
            res.reg_wr = 1'b1;
            res.value  = opnd_b >> opnd_a[4:0];
         end
         FN_SRAV: begin
            res.reg_wr = 1'b1;
            res.value  = $signed(opnd_b) >>> opnd_a[4:0];
         end
         FN_JR: begin
            if (opnd_a[1:0] != 2'd0) begin
               res.status = STAT_MISALIGN;
            end else begin
               res.jump   = 1'b1;
               res.target = opnd_a[31:2];
            end
         end
         FN_MFHI: begin
            res.reg_wr = 1'b1;
            res.value  = hi;
         end
         FN_MFLO: begin
            res.reg_wr = 1'b1;
            res.value  = lo;
         end
         FN_MTHI: begin
            res.hi_wr = 1'b1;
         end
         FN_MTLO: begin
            res.lo_wr = 1'b1;
         end
         FN_MULT: begin
            res.md_start  = 1'b1;
            res.md_signed = 1'b1;
         end
         FN_MULTU: begin
            res.md_start = 1'b1;
         end
         // A zero divisor leaves Hi and Lo as they are, so the unit is not started.
         FN_DIV: begin
            res.md_start  = (opnd_b != 32'd0);
            res.md_div    = 1'b1;
            res.md_signed = 1'b1;
         end
         FN_DIVU: begin
            res.md_start = (opnd_b != 32'd0);
            res.md_div   = 1'b1;
         end
         default: begin
            res.status = STAT_RESERVED;
         end
      endcase
   end

endmodule

// ===== rtl/rteu_muldiv.sv =====
`timescale 1ns / 1ps
// Radix-2 iterative multiply/divide unit: 32 shift-add or restoring-divide
// steps on magnitudes, then a sign fixup state (MD_FIX). Depends on rteu_pkg.
module rteu_muldiv import rteu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  md_ctrl_type ctrl,
   input  logic [31:0] opnd_a,
   input  logic [31:0] opnd_b,
   output md_stat_type stat
);

   md_state_type state_ff, state_in;
   logic [63:0]  acc_ff, acc_in;
   logic [31:0]  opnd_ff, opnd_in;
   logic [4:0]   count_ff, count_in;
   logic         div_ff, div_in;
   logic         neg_q_ff, neg_q_in;
   logic         neg_r_ff, neg_r_in;

   logic [31:0]  mag_a;
   logic [31:0]  mag_b;
   logic [32:0]  mul_sum;
   logic [32:0]  rem_sh;
   logic [32:0]  div_diff;
   logic [63:0]  mul_step;
   logic [63:0]  div_step;

   assign mag_a = (ctrl.is_signed && opnd_a[31]) ? (32'd0 - opnd_a) : opnd_a;
   assign mag_b = (ctrl.is_signed && opnd_b[31]) ? (32'd0 - opnd_b) : opnd_b;

   // Multiply: add the multiplicand into the upper half when the low bit is set,
   // then shift the whole accumulator right.
   assign mul_sum  = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, opnd_ff} : 33'd0);
   assign mul_step = {mul_sum, acc_ff[31:1]};

   // Divide: the partial remainder sits in the upper half, the quotient
   // shifts in from the right as the dividend shifts out.
   assign rem_sh   = acc_ff[63:31];
   assign div_diff = rem_sh - {1'b0, opnd_ff};
   assign div_step = div_diff[32] ? {rem_sh[31:0], acc_ff[30:0], 1'b0}
                                  : {div_diff[31:0], acc_ff[30:0], 1'b1};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      opnd_in  = opnd_ff;
      count_in = count_ff;
      div_in   = div_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      case (state_ff)
         MD_IDLE: begin
            if (ctrl.start) begin
               acc_in   = {32'd0, ctrl.is_div ? mag_a : mag_b};
               opnd_in  = ctrl.is_div ? mag_b : mag_a;
               count_in = '0;
               div_in   = ctrl.is_div;
               neg_q_in = ctrl.is_signed & (opnd_a[31] ^ opnd_b[31]);
               neg_r_in = ctrl.is_signed & opnd_a[31];
               state_in = MD_RUN;
            end
         end
         MD_RUN: begin
            acc_in   = div_ff ? div_step : mul_step;
            count_in = count_ff + 5'd1;
            if (count_ff == 5'(MD_STEPS - 1)) begin
               state_in = MD_FIX;
            end
         end
         MD_FIX: begin
            if (div_ff) begin
               acc_in = {neg_r_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32],
                         neg_q_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0]};
            end else begin
               acc_in = neg_q_ff ? (64'd0 - acc_ff) : acc_ff;
            end
            state_in = MD_DONE;
         end
         MD_DONE: begin
            if (ctrl.ack) begin
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      acc_ff   <= acc_in;
      opnd_ff  <= opnd_in;
      div_ff   <= div_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign stat.done = (state_ff == MD_DONE);
   assign stat.hi   = acc_ff[63:32];
   assign stat.lo   = acc_ff[31:0];

endmodule

// ===== rtl/r_type_execute_unit_core.sv =====
`timescale 1ns / 1ps
// Top level of the R-type execute unit: handshakes, sequencing, Hi/Lo and
// the result register. Depends on rteu_pkg, rteu_regfile, rteu_alu, rteu_muldiv.

// One transaction in, one result out. Each request is either an R-type
// instruction word executed against the 32-entry register file and Hi/Lo, or
// (tuser high) a direct load of one register. Requests are handled one at a
// time: rs and rt are read from the synchronous register file as the request
// is accepted, then ST_EXEC executes and writes back. mult, multu, div and divu
// go on to ST_MULDIV and wait for the radix-2 multiply/divide unit (32 steps
// plus start, sign fixup and hand-back); a division by zero finishes in ST_EXEC
// and leaves Hi and Lo unchanged. The result sits in an output register, so the
// next request is accepted while a finished result still waits for rsp_tready.
// Register zero always reads zero and is never written. Traps and unknown
// function codes report a nonzero status and change no state.
module r_type_execute_unit_core import rteu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] instruction, [36:32] load_index, [68:37] load_value, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] reg_written, [5:1] dest_index, [37:6] dest_value, [69:38] hi_value,
   // [101:70] lo_value, [102] jump_taken, [132:103] jump_target, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]             rsp_tuser
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [31:0]    hi_ff, hi_in;
   logic [31:0]    lo_ff, lo_in;

   logic           mode_ff;
   logic [31:0]    instr_ff;
   logic [4:0]     load_index_ff;
   logic [31:0]    load_value_ff;

   logic           accept;
   logic           out_free;
   logic           load_out;
   logic           rf_rd_en;
   logic [31:0]    opnd_a;
   logic [31:0]    opnd_b;
   logic           rf_wr_en;
   alu_res_type    alu_res;
   md_ctrl_type    md_ctrl;
   md_stat_type    md_stat;

   logic           exec_wr;
   logic [4:0]     exec_idx;
   logic [31:0]    exec_val;

   assign accept   = req_tvalid & req_tready;
   assign out_free = ~rsp_valid_ff | rsp_tready;

   rteu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rf_rd_en),
      .rd_addr_a (req_tdata[25:21]),
      .rd_addr_b (req_tdata[20:16]),
      .rd_data_a (opnd_a),
      .rd_data_b (opnd_b),
      .wr_en     (rf_wr_en),
      .wr_addr   (exec_idx),
      .wr_data   (exec_val)
   );

   rteu_alu u_alu (
      .funct  (instr_ff[5:0]),
      .shamt  (instr_ff[10:6]),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .hi     (hi_ff),
      .lo     (lo_ff),
      .res    (alu_res)
   );

   rteu_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .stat   (md_stat)
   );

   // Destination of the current item; a write to register zero is dropped.
   always_comb begin
      if (mode_ff) begin
         exec_wr  = (load_index_ff != 5'd0);
         exec_idx = load_index_ff;
         exec_val = load_value_ff;
      end else begin
         exec_wr  = alu_res.reg_wr && (instr_ff[15:11] != 5'd0);
         exec_idx = instr_ff[15:11];
         exec_val = alu_res.value;
      end
      if (!exec_wr) begin
         exec_idx = '0;
         exec_val = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rf_rd_en   = 1'b0;
      rf_wr_en   = 1'b0;
      load_out   = 1'b0;
      md_ctrl    = '0;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rf_rd_en = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!mode_ff && alu_res.md_start) begin
               md_ctrl.start     = 1'b1;
               md_ctrl.is_div    = alu_res.md_div;
               md_ctrl.is_signed = alu_res.md_signed;
               state_in          = ST_MULDIV;
            end else if (out_free) begin
               load_out = 1'b1;
               rf_wr_en = exec_wr;
               if (!mode_ff && alu_res.hi_wr) begin
                  hi_in = opnd_a;
               end
               if (!mode_ff && alu_res.lo_wr) begin
                  lo_in = opnd_a;
               end
               rsp_in.status      = mode_ff ? STAT_OK : alu_res.status;
               rsp_in.reg_written = exec_wr;
               rsp_in.dest_index  = exec_idx;
               rsp_in.dest_value  = exec_val;
               rsp_in.hi_value    = hi_in;
               rsp_in.lo_value    = lo_in;
               rsp_in.jump_taken  = ~mode_ff & alu_res.jump;
               rsp_in.jump_target = mode_ff ? 30'd0 : alu_res.target;
               state_in           = ST_IDLE;
            end
         end
         ST_MULDIV: begin
            if (md_stat.done && out_free) begin
               md_ctrl.ack        = 1'b1;
               load_out           = 1'b1;
               hi_in              = md_stat.hi;
               lo_in              = md_stat.lo;
               rsp_in.status      = STAT_OK;
               rsp_in.reg_written = 1'b0;
               rsp_in.dest_index  = '0;
               rsp_in.dest_value  = '0;
               rsp_in.hi_value    = md_stat.hi;
               rsp_in.lo_value    = md_stat.lo;
               rsp_in.jump_taken  = 1'b0;
               rsp_in.jump_target = '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
      if (accept) begin
         mode_ff       <= req_tuser;
         instr_ff      <= req_tdata[31:0];
         load_index_ff <= req_tdata[36:32];
         load_value_ff <= req_tdata[68:37];
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'd0, rsp_ff.jump_target, rsp_ff.jump_taken, rsp_ff.lo_value,
                        rsp_ff.hi_value, rsp_ff.dest_value, rsp_ff.dest_index,
                        rsp_ff.reg_written};

endmodule

// ===== rtl/rteu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the R-type execute unit, bound to its top level.
// Depends on rteu_pkg and r_type_execute_unit_core.
module rteu_checker import rteu_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one transaction is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // Without a register write the destination fields are zero.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[37:1] == 37'd0)
      else $error("destination fields set without a write");

   // A write never targets register zero and never comes with an error.
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[5:1] != 5'd0 && rsp_tuser == STAT_OK)
      else $error("bad register write in result");

   // A taken jump writes nothing and is error free; otherwise the target is zero.
   a_jump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[102] && !rsp_tdata[0] && rsp_tuser == STAT_OK) ||
                     (!rsp_tdata[102] && rsp_tdata[132:103] == 30'd0))
      else $error("inconsistent jump fields");

endmodule

bind r_type_execute_unit_core rteu_checker u_rteu_checker (.*);

// ===== verif/tb_r_type_execute_unit_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for r_type_execute_unit_core: a directed table and
// random traffic, checked against a behavioral execute model or, for typed
// table rows, their own expected results. Depends on rteu_pkg and the block's RTL.
module tb_r_type_execute_unit_core;
   import rteu_pkg::*;

   typedef struct {
      logic        mode;
      logic [31:0] instr;
      logic [4:0]  load_index;
      logic [31:0] load_value;
      logic        typed;
      rsp_type     want;
   } req_entry_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   // Architectural state as the execute model sees it.
   logic [31:0] gpr [NUM_REGS];
   logic [31:0] hi_q;
   logic [31:0] lo_q;

   rsp_type     expected_retire_q [$];
   int          mismatch_count = 0;
   int          idle_pct = 25;

   localparam logic [5:0] LEGAL_FN [24] = '{
      FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_MFHI,
      FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD,
      FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU
   };

   r_type_execute_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd,
                                         input logic [4:0] sh);
      return {6'b0, rs, rt, rd, sh, fn};
   endfunction

   function automatic req_entry_type exec_row(input logic [31:0] instr);
      req_entry_type e;
      e.mode       = 1'b0;
      e.instr      = instr;
      e.load_index = '0;
      e.load_value = '0;
      e.typed      = 1'b0;
      e.want       = '0;
      return e;
   endfunction

   function automatic req_entry_type load_row(input logic [4:0] idx, input logic [31:0] val);
      req_entry_type e;
      e            = exec_row('0);
      e.mode       = 1'b1;
      e.load_index = idx;
      e.load_value = val;
      return e;
   endfunction

   function automatic req_entry_type with_want(input req_entry_type e, input logic [1:0] st,
                                               input logic wr, input logic [4:0] idx,
                                               input logic [31:0] val, input logic [31:0] hi,
                                               input logic [31:0] lo, input logic jt,
                                               input logic [29:0] tgt);
      req_entry_type r;
      r                  = e;
      r.typed            = 1'b1;
      r.want.status      = st;
      r.want.reg_written = wr;
      r.want.dest_index  = idx;
      r.want.dest_value  = val;
      r.want.hi_value    = hi;
      r.want.lo_value    = lo;
      r.want.jump_taken  = jt;
      r.want.jump_target = tgt;
      return r;
   endfunction

   // Executes one transaction on the model state and returns the result it retires.
   function automatic rsp_type execute_r_type(input req_entry_type e);
      rsp_type     r;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] sum;
      logic [63:0] prod;
      logic [4:0]  sh;
      logic        wr;
      r  = '0;
      wr = 1'b1;
      sh = e.instr[10:6];
      a  = gpr[e.instr[25:21]];
      b  = gpr[e.instr[20:16]];
      if (e.mode) begin
         r.dest_index = e.load_index;
         r.dest_value = e.load_value;
      end else begin
         r.dest_index = e.instr[15:11];
         case (e.instr[5:0])
            FN_ADD: begin
               sum = a + b;
               if (a[31] == b[31] && sum[31] != a[31]) begin
                  r.status = STAT_OVERFLOW;
                  wr = 1'b0;
               end else begin
                  r.dest_value = sum;
               end
            end
            FN_SUB: begin
               sum = a - b;
               if (a[31] != b[31] && sum[31] != a[31]) begin
                  r.status = STAT_OVERFLOW;
                  wr = 1'b0;
               end else begin
                  r.dest_value = sum;
               end
            end
            FN_ADDU: r.dest_value = a + b;
            FN_SUBU: r.dest_value = a - b;
            FN_AND:  r.dest_value = a & b;
            FN_OR:   r.dest_value = a | b;
            FN_NOR:  r.dest_value = ~(a | b);
            FN_SLT:  r.dest_value = {31'b0, $signed(a) < $signed(b)};
            FN_SLTU: r.dest_value = {31'b0, a < b};
            FN_SLL:  r.dest_value = b << sh;
            FN_SRL:  r.dest_value = b >> sh;
            FN_SRA:  r.dest_value = $signed(b) >>> sh;
            FN_SLLV: r.dest_value = b << a[4:0];
            FN_SRLV: r.dest_value = b >> a[4:0];
            FN_SRAV: r.dest_value = $signed(b) >>> a[4:0];
            FN_MFHI: r.dest_value = hi_q;
            FN_MFLO: r.dest_value = lo_q;
            FN_JR: begin
               wr = 1'b0;
               if (a[1:0] != 2'b00) begin
                  r.status = STAT_MISALIGN;
               end else begin
                  r.jump_taken  = 1'b1;
                  r.jump_target = a[31:2];
               end
            end
            FN_MTHI: begin
               wr   = 1'b0;
               hi_q = a;
            end
            FN_MTLO: begin
               wr   = 1'b0;
               lo_q = a;
            end
            FN_MULT: begin
               wr   = 1'b0;
               // The low 64 bits of the product of sign-extended operands are
               // the signed product.
               prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
               {hi_q, lo_q} = prod;
            end
            FN_MULTU: begin
               wr   = 1'b0;
               prod = {32'b0, a} * {32'b0, b};
               {hi_q, lo_q} = prod;
            end
            FN_DIV: begin
               wr = 1'b0;
               if (b != 32'b0) begin
                  if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                     lo_q = a;
                     hi_q = 32'b0;
                  end else begin
                     lo_q = $signed(a) / $signed(b);
                     hi_q = $signed(a) % $signed(b);
                  end
               end
            end
            FN_DIVU: begin
               wr = 1'b0;
               if (b != 32'b0) begin
                  lo_q = a / b;
                  hi_q = a % b;
               end
            end
            default: begin
               wr       = 1'b0;
               r.status = STAT_RESERVED;
            end
         endcase
      end
      if (wr && r.dest_index != 5'd0) begin
         gpr[r.dest_index] = r.dest_value;
      end else begin
         wr           = 1'b0;
         r.dest_index = '0;
         r.dest_value = '0;
      end
      r.reg_written = wr;
      r.hi_value    = hi_q;
      r.lo_value    = lo_q;
      return r;
   endfunction

   // Operand values biased toward the corners of add, sub, div and jr.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4: return $urandom_range(0, 8);
         5: return $urandom() & 32'hFFFF_FFFC;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_entry_type random_req();
      req_entry_type e;
      logic [5:0]    fn;
      if ($urandom_range(0, 3) == 0) begin
         e = load_row(5'($urandom_range(0, 31)), pick_word());
         e.instr = $urandom();
      end else begin
         fn = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                         : LEGAL_FN[5'($urandom_range(0, 23))];
         e = exec_row({$urandom()} & 32'hFFFF_FFC0 | {26'b0, fn});
         e.load_index = 5'($urandom_range(0, 31));
         e.load_value = $urandom();
      end
      return e;
   endfunction

   // Presents one transaction, holds it until accepted and records its result.
   task automatic send_req(input req_entry_type e);
      rsp_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= e.mode;
      req_tdata  <= {3'b0, e.load_value, e.load_index, e.instr};
      do @(posedge clock); while (!req_tready);
      predicted = execute_r_type(e);
      expected_retire_q.push_back(e.typed ? e.want : predicted);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: random back-pressure and comparison in retirement order.
   initial begin : rsp_side
      int      stall_left;
      rsp_type want;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_retire_q.size() == 0) begin
               $error("result transaction with no outstanding request");
               mismatch_count++;
            end else begin
               want = expected_retire_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("reg_written", 32'(want.reg_written), 32'(rsp_tdata[0]));
               check_field("dest_index", 32'(want.dest_index), 32'(rsp_tdata[5:1]));
               check_field("dest_value", want.dest_value, rsp_tdata[37:6]);
               check_field("hi_value", want.hi_value, rsp_tdata[69:38]);
               check_field("lo_value", want.lo_value, rsp_tdata[101:70]);
               check_field("jump_taken", 32'(want.jump_taken), 32'(rsp_tdata[102]));
               check_field("jump_target", 32'(want.jump_target),
                           32'(rsp_tdata[132:103]));
            end
         end
         @(negedge clock);
         if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_entry_type dir_rows [$];
      int            n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      hi_q       = '0;
      lo_q       = '0;
      foreach (gpr[i]) gpr[i] = '0;

      // State right after reset, the reserved-instruction trap and the loads
      // that set up the operand corners.
      dir_rows.push_back(with_want(exec_row(rtype(FN_MFHI, 0, 0, 1, 0)),
                                   STAT_OK, 1, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(with_want(exec_row({6'h3F, 20'hFFFFF, 6'h01}),
                                   STAT_RESERVED, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(with_want(load_row(1, 32'h7FFF_FFFF),
                                   STAT_OK, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0));
      dir_rows.push_back(with_want(load_row(2, 32'h8000_0000),
                                   STAT_OK, 1, 2, 32'h8000_0000, 0, 0, 0, 0));
      dir_rows.push_back(with_want(load_row(3, 32'hFFFF_FFFF),
                                   STAT_OK, 1, 3, 32'hFFFF_FFFF, 0, 0, 0, 0));
      dir_rows.push_back(with_want(load_row(4, 32'h0000_0001),
                                   STAT_OK, 1, 4, 32'h0000_0001, 0, 0, 0, 0));
      // A load into register zero is dropped even with a busy instruction field.
      dir_rows.push_back(with_want(load_row(0, 32'h1234_5678), STAT_OK, 0, 0, 0, 0, 0, 0, 0));
      dir_rows[$].instr = 32'hFFFF_FFFF;
      dir_rows.push_back(with_want(exec_row(rtype(FN_ADD, 1, 4, 5, 0)),
                                   STAT_OVERFLOW, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(with_want(exec_row(rtype(FN_SUB, 2, 4, 5, 0)),
                                   STAT_OVERFLOW, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(with_want(exec_row(rtype(FN_JR, 2, 0, 0, 0)),
                                   STAT_OK, 0, 0, 0, 0, 0, 1, 30'h2000_0000));
      dir_rows.push_back(with_want(exec_row(rtype(FN_JR, 3, 0, 0, 0)),
                                   STAT_MISALIGN, 0, 0, 0, 0, 0, 0, 0));
      // Most negative value divided by minus one.
      dir_rows.push_back(with_want(exec_row(rtype(FN_DIV, 2, 3, 0, 0)),
                                   STAT_OK, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
      dir_rows.push_back(exec_row(rtype(FN_DIVU, 1, 0, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_DIV, 3, 0, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MULT, 2, 3, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MFHI, 0, 0, 6, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MULTU, 3, 3, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MFLO, 0, 0, 7, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MTHI, 1, 0, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_MTLO, 2, 0, 0, 0)));
      dir_rows.push_back(exec_row(rtype(FN_SLT, 2, 1, 8, 0)));
      dir_rows.push_back(exec_row(rtype(FN_SLTU, 2, 1, 9, 0)));
      dir_rows.push_back(exec_row(rtype(FN_SRA, 0, 2, 10, 31)));
      dir_rows.push_back(exec_row(rtype(FN_SRAV, 3, 2, 11, 0)));
      dir_rows.push_back(exec_row(rtype(FN_NOR, 0, 0, 0, 0)));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_req(dir_rows[i]);

      for (n = 0; n < 600; n++) begin
         if (n >= 500) begin
            idle_pct = 0;
         end else if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         send_req(random_req());
      end
      req_tvalid <= 1'b0;

      while (expected_retire_q.size() != 0) @(posedge clock);
      // Long enough for a multiply or divide still in flight to show up.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      // Ends the run as failed if it hangs.
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rteu_pkg.sv
rtl/rteu_regfile.sv
rtl/rteu_alu.sv
rtl/rteu_muldiv.sv
rtl/r_type_execute_unit_core.sv
rtl/rteu_checker.sv
verif/tb_r_type_execute_unit_core.sv
